### rtl/ihss_pkg.sv
`timescale 1ns / 1ps

package ihss_pkg;

    localparam int HISTORY_DEPTH_DEF = 3;

    localparam int ACTION_W = 2;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GET  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_PUSH_LOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd2;

    typedef struct packed {
        logic step;
    } ihss_cmd_t;

endpackage

### rtl/importance_history_shift_stack_unit.sv
`timescale 1ns / 1ps
// The result beat is valid in the cycle after the input beat is taken.
// Throughput: one request per cycle while m_tready is high; the output register frees as it drains.
// Shift and parallel height compare over the history are computed combinationally.
// Reset (rst_n low, async): history cleared and marked empty, no beat pending.

module importance_history_shift_stack_unit
    import ihss_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*DATA_W-1:0]   s_tdata,   // importance_value, height_value
    input  logic [ACTION_W-1:0]   s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*DATA_W-1:0]   m_tdata,   // found_value, front_value, front_height
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    ihss_cmd_t         cmd;
    logic [DATA_W-1:0] found_value;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] front_height;

    ihss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ihss_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (s_tuser),
        .importance_value (s_tdata[DATA_W-1:0]),
        .height_value     (s_tdata[2*DATA_W-1:DATA_W]),
        .status           (m_tuser),
        .found_value      (found_value),
        .front_value      (front_value),
        .front_height     (front_height)
    );

    assign m_tdata = {front_height, front_value, found_value};

endmodule

### rtl/ihss_ctrl.sv
`timescale 1ns / 1ps

module ihss_ctrl
    import ihss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ihss_cmd_t cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign m_tvalid = (state_reg == ST_FULL);
    assign s_tready = (state_reg == ST_EMPTY) || m_tready;
    assign cmd.step = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (cmd.step)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (cmd.step)
                begin
                    state_next = ST_FULL;
                end
                else if (m_tready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> state_reg == ST_FULL)
        else $error("result beat missing after step");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FULL && m_tready && !s_tvalid) |=> state_reg == ST_EMPTY)
        else $error("output not released after drain");

endmodule

### rtl/ihss_dpath.sv
`timescale 1ns / 1ps

module ihss_dpath
    import ihss_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ihss_cmd_t           cmd,
    input  logic [ACTION_W-1:0] action,
    input  logic [DATA_W-1:0]   importance_value,
    input  logic [DATA_W-1:0]   height_value,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   found_value,
    output logic [DATA_W-1:0]   front_value,
    output logic [DATA_W-1:0]   front_height
);

    logic [DATA_W-1:0]   vals_reg [HISTORY_DEPTH];
    logic [DATA_W-1:0]   vals_next [HISTORY_DEPTH];
    logic [DATA_W-1:0]   hts_reg [HISTORY_DEPTH];
    logic [DATA_W-1:0]   hts_next [HISTORY_DEPTH];
    logic                present_reg;
    logic                present_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   found_reg;
    logic [DATA_W-1:0]   found_next;

    assign front_value  = present_reg ? vals_reg[0] : '0;
    assign front_height = present_reg ? hts_reg[0] : '0;
    assign status       = status_reg;
    assign found_value  = found_reg;

    always_comb
    begin
        vals_next    = vals_reg;
        hts_next     = hts_reg;
        present_next = present_reg;
        status_next  = STAT_OK;
        found_next   = '0;
        case (action)
            ACT_PUSH:
            begin
                if (height_value <= front_height)
                begin
                    status_next = STAT_PUSH_LOW;
                end
                else
                begin
                    for (int i = 1; i < HISTORY_DEPTH; i++)
                    begin
                        vals_next[i] = vals_reg[i-1];
                        hts_next[i]  = hts_reg[i-1];
                    end
                    vals_next[0] = importance_value;
                    hts_next[0]  = height_value;
                    present_next = 1'b1;
                end
            end
            ACT_POP:
            begin
                if (!present_reg)
                begin
                    status_next = STAT_POP_EMPTY;
                end
                else if (vals_reg[1] == '0)
                begin
                    // new front would be zero: drop the whole history
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                    begin
                        vals_next[i] = '0;
                        hts_next[i]  = '0;
                    end
                    present_next = 1'b0;
                end
                else
                begin
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    begin
                        vals_next[i] = vals_reg[i+1];
                        hts_next[i]  = hts_reg[i+1];
                    end
                    vals_next[HISTORY_DEPTH-1] = '0;
                    hts_next[HISTORY_DEPTH-1]  = '0;
                end
            end
            ACT_GET:
            begin
                // walk from the old end so the newest match wins
                if (present_reg)
                begin
                    for (int i = HISTORY_DEPTH - 1; i >= 0; i--)
                    begin
                        if (hts_reg[i] == height_value)
                        begin
                            found_next = vals_reg[i];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                vals_reg[i] <= '0;
                hts_reg[i]  <= '0;
            end
            present_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            vals_reg    <= vals_next;
            hts_reg     <= hts_next;
            present_reg <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    a_empty_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !present_reg |-> (vals_reg[0] == '0 && hts_reg[0] == '0))
        else $error("empty history holds stale front");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && action == ACT_PUSH && height_value > front_height)
        |=> (present_reg && hts_reg[0] == $past(height_value)
             && status_reg == STAT_OK))
        else $error("accepted push not at front");

    a_pop_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && action == ACT_POP && !present_reg)
        |=> (status_reg == STAT_POP_EMPTY && !present_reg))
        else $error("pop on empty not flagged");

endmodule
